>>> sv/pfu_pkg.sv
// Shared constants for the MSB-first packed field unpacker.
package pfu_pkg;

    localparam int MAX_WIDTH  = 24;
    localparam int COUNT_BITS = 16;
    localparam int BUF_BITS   = 32;
    localparam int HELD_BITS  = 6;
    localparam int WIDTH_BITS = 5;
    localparam int VALUE_BITS = 24;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BITS_PER_VALUE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VALUE_COUNT    = 1'd1;

    localparam logic [WIDTH_BITS-1:0] BITS_RESET  = 5'd8;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 16'd3447;

endpackage

>>> sv/packed_field_unpacker.sv
// Top level of the MSB-first packed field unpacker.
//
// Input requests carry one byte of a packed bit stream (s_data_byte) and a
// flag (s_first_byte) that starts a new message, clearing the bit buffer and
// the value counter. Each value of bits_per_value bits (1..24) is returned on
// the result channel, most significant bit first, zero-extended in m_value;
// m_last_value marks value number value_count of the message. After that,
// padding bits and further bytes without the flag are dropped.
// A completing byte is first held in the bit buffer; its value then moves to
// the result register once that register is free. One value leaves per cycle
// while the receiver does not stall, so a byte is taken every cycle for widths
// of 8 and more; narrower widths hold a byte until its values have all moved
// through the single result register. The next byte is taken in the cycle
// that the last pending value of the current one moves to the result register.
// Reset (aresetn low, synchronous) restores bits_per_value 8 and
// value_count 3447 and empties the buffer, counter and result register.
// When the receiver stalls, the result register holds and s_ready drops
// while values of the current byte are still waiting.
module packed_field_unpacker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 s_first_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pfu_pkg::VALUE_BITS-1:0]       m_value,
    output logic                                 m_last_value,
    input  logic                                 cfg_wr_en,
    input  logic [pfu_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pfu_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    logic [pfu_pkg::WIDTH_BITS-1:0] bpv_reg;
    logic [pfu_pkg::COUNT_BITS-1:0] count_reg;
    logic [pfu_pkg::BUF_BITS-1:0]   buf_reg, buf_next;
    logic [pfu_pkg::HELD_BITS-1:0]  held_reg, held_next;
    logic [pfu_pkg::COUNT_BITS-1:0] given_reg, given_next;
    logic                           active_reg, active_next;
    logic [2:0]                     burst_reg, burst_next;
    logic                           m_valid_reg;
    logic [pfu_pkg::VALUE_BITS-1:0] m_value_reg;
    logic                           m_last_reg;

    logic [pfu_pkg::WIDTH_BITS-1:0] width;
    logic [pfu_pkg::BUF_BITS-1:0]   mask;
    logic [pfu_pkg::BUF_BITS-1:0]   extracted;
    logic [pfu_pkg::HELD_BITS-1:0]  held_after;
    logic [pfu_pkg::COUNT_BITS-1:0] given_after;
    logic                           still_active;
    logic                           out_free;
    logic                           emit_fire;
    logic                           s_fire;
    logic [pfu_pkg::BUF_BITS-1:0]   buf_base;
    logic [pfu_pkg::HELD_BITS-1:0]  held_base;
    logic [pfu_pkg::COUNT_BITS-1:0] given_base;
    logic [pfu_pkg::HELD_BITS-1:0]  held_grown;

    always_comb begin
        if (bpv_reg == '0) begin
            width = pfu_pkg::WIDTH_BITS'(1);
        end else if (bpv_reg > pfu_pkg::WIDTH_BITS'(pfu_pkg::MAX_WIDTH)) begin
            width = pfu_pkg::WIDTH_BITS'(pfu_pkg::MAX_WIDTH);
        end else begin
            width = bpv_reg;
        end
    end

    assign mask         = (pfu_pkg::BUF_BITS'(1) << width) - pfu_pkg::BUF_BITS'(1);
    assign held_after   = held_reg - {1'b0, width};
    assign extracted    = (buf_reg >> held_after[pfu_pkg::WIDTH_BITS-1:0]) & mask;
    assign given_after  = given_reg + pfu_pkg::COUNT_BITS'(1);
    assign still_active = (held_after >= {1'b0, width}) && (given_after < count_reg)
                          && (burst_reg != 3'd7);

    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = active_reg && out_free;
    assign s_ready   = !active_reg || (out_free && !still_active);
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        buf_base   = buf_reg;
        held_base  = emit_fire ? held_after : held_reg;
        given_base = emit_fire ? given_after : given_reg;
        burst_next = emit_fire ? burst_reg + 3'd1 : burst_reg;
        if (s_fire && s_first_byte) begin
            buf_base   = '0;
            held_base  = '0;
            given_base = '0;
        end
        held_grown  = held_base + pfu_pkg::HELD_BITS'(8);
        buf_next    = buf_base;
        held_next   = held_base;
        given_next  = given_base;
        active_next = emit_fire ? still_active : active_reg;
        if (s_fire) begin
            burst_next = '0;
            if (given_base >= count_reg) begin
                active_next = 1'b0;
            end else begin
                buf_next    = {buf_base[pfu_pkg::BUF_BITS-9:0], s_data_byte};
                held_next   = held_grown;
                active_next = held_grown >= {1'b0, width};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpv_reg     <= pfu_pkg::BITS_RESET;
            count_reg   <= pfu_pkg::COUNT_RESET;
            buf_reg     <= '0;
            held_reg    <= '0;
            given_reg   <= '0;
            active_reg  <= 1'b0;
            burst_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    pfu_pkg::CFG_BITS_PER_VALUE: begin
                        bpv_reg <= cfg_wdata[pfu_pkg::WIDTH_BITS-1:0];
                    end
                    pfu_pkg::CFG_VALUE_COUNT: begin
                        count_reg <= cfg_wdata[pfu_pkg::COUNT_BITS-1:0];
                    end
                endcase
            end
            buf_reg    <= buf_next;
            held_reg   <= held_next;
            given_reg  <= given_next;
            active_reg <= active_next;
            burst_reg  <= burst_next;
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_value_reg <= extracted[pfu_pkg::VALUE_BITS-1:0];
            m_last_reg  <= !(given_after < count_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_last_value = m_last_reg;

endmodule
